FILE: sv/bslf_pkg.sv
package bslf_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int POS_W = 6;
    localparam logic [POS_W-1:0] POS_MAX = '1;
    localparam logic [POS_W-1:0] POS_ETH_HI = POS_W'(12);
    localparam logic [POS_W-1:0] POS_ETH_LO = POS_W'(13);
    localparam logic [POS_W-1:0] POS_SRC_FIRST = POS_W'(26);
    localparam logic [POS_W-1:0] POS_SRC_LAST = POS_W'(29);
    localparam logic [POS_W-1:0] MIN_FRAME_BYTES = POS_W'(34);
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

    localparam logic [1:0] REQ_FRAME  = 2'd0;
    localparam logic [1:0] REQ_INSERT = 2'd1;
    localparam logic [1:0] REQ_REMOVE = 2'd2;
    localparam logic [1:0] REQ_READ   = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_PRESENT   = 2'd3;

    typedef struct packed {
        logic        valid;
        logic        eligible;
        logic [31:0] source;
    } frame_done_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  op;
        logic [31:0] key;
    } table_req_t;

    typedef struct packed {
        logic        valid;
        logic [1:0]  kind;
        logic        drop;
        logic [1:0]  status;
        logic [31:0] hits;
    } table_resp_t;

endpackage

FILE: sv/bslf_parser.sv
module bslf_parser (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     beat,
    input  logic [7:0]               data_byte,
    input  logic                     last_byte,
    output bslf_pkg::frame_done_t    frame_done
);

    logic [bslf_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0]                eth_reg, eth_next;
    logic [31:0]                src_reg, src_next;
    logic [15:0]                eth_new;
    logic [31:0]                src_new;

    always_comb
    begin
        eth_new = eth_reg;
        src_new = src_reg;
        if (pos_reg == bslf_pkg::POS_ETH_HI || pos_reg == bslf_pkg::POS_ETH_LO)
        begin
            eth_new = {eth_reg[7:0], data_byte};
        end
        else if (pos_reg >= bslf_pkg::POS_SRC_FIRST && pos_reg <= bslf_pkg::POS_SRC_LAST)
        begin
            src_new = {src_reg[23:0], data_byte};
        end

        pos_next = pos_reg;
        eth_next = eth_reg;
        src_next = src_reg;
        frame_done.valid = 1'b0;
        frame_done.eligible = 1'b0;
        frame_done.source = src_new;
        if (beat)
        begin
            if (last_byte)
            begin
                pos_next = '0;
                eth_next = '0;
                src_next = '0;
                frame_done.valid = 1'b1;
                frame_done.eligible = (pos_reg >= bslf_pkg::MIN_FRAME_BYTES - 1'b1)
                                      && (eth_new == bslf_pkg::ETHERTYPE_IPV4);
            end
            else
            begin
                eth_next = eth_new;
                src_next = src_new;
                if (pos_reg != bslf_pkg::POS_MAX)
                begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            eth_reg <= '0;
            src_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            eth_reg <= eth_next;
            src_reg <= src_next;
        end
    end

endmodule

FILE: sv/bslf_table.sv
module bslf_table (
    input  logic                     clk,
    input  logic                     rst_n,
    input  bslf_pkg::table_req_t     req,
    output bslf_pkg::table_resp_t    resp,
    output logic                     busy
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    localparam logic [bslf_pkg::IDX_W-1:0] LAST_IDX =
        bslf_pkg::IDX_W'(bslf_pkg::TABLE_ENTRIES - 1);
    localparam logic [bslf_pkg::CNT_W-1:0] ENTRY_COUNT =
        bslf_pkg::CNT_W'(bslf_pkg::TABLE_ENTRIES);

    // Bit 32 of an address word is the entry's valid flag.
    logic [32:0] addr_mem [bslf_pkg::TABLE_ENTRIES];
    logic [31:0] hits_mem [bslf_pkg::TABLE_ENTRIES];

    logic [1:0]                    state_reg, state_next;
    logic [bslf_pkg::IDX_W-1:0]    clr_idx_reg, clr_idx_next;
    logic [bslf_pkg::CNT_W-1:0]    issue_idx_reg, issue_idx_next;
    logic                          rd_pend_reg, rd_pend_next;
    logic [bslf_pkg::IDX_W-1:0]    rd_idx_reg, rd_idx_next;
    logic [31:0]                   key_reg, key_next;
    logic [1:0]                    op_reg, op_next;
    logic                          free_found_reg, free_found_next;
    logic [bslf_pkg::IDX_W-1:0]    free_idx_reg, free_idx_next;
    logic [32:0]                   addr_rd_reg;
    logic [31:0]                   hits_rd_reg;

    logic                          mem_re;
    logic [bslf_pkg::IDX_W-1:0]    mem_raddr;
    logic                          am_we;
    logic [bslf_pkg::IDX_W-1:0]    am_waddr;
    logic [32:0]                   am_wdata;
    logic                          hm_we;
    logic [bslf_pkg::IDX_W-1:0]    hm_waddr;
    logic [31:0]                   hm_wdata;

    logic                          hit;
    logic                          free_now;
    logic                          scan_end;
    logic                          free_any;
    logic [bslf_pkg::IDX_W-1:0]    free_sel;

    assign hit = rd_pend_reg && addr_rd_reg[32] && (addr_rd_reg[31:0] == key_reg);
    assign free_now = rd_pend_reg && !addr_rd_reg[32];
    assign scan_end = rd_pend_reg && (hit || rd_idx_reg == LAST_IDX);
    assign free_any = free_found_reg || free_now;
    assign free_sel = free_found_reg ? free_idx_reg : rd_idx_reg;
    assign busy = (state_reg != S_IDLE);
    assign mem_raddr = issue_idx_reg[bslf_pkg::IDX_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        clr_idx_next = clr_idx_reg;
        issue_idx_next = issue_idx_reg;
        rd_pend_next = rd_pend_reg;
        rd_idx_next = rd_idx_reg;
        key_next = key_reg;
        op_next = op_reg;
        free_found_next = free_found_reg;
        free_idx_next = free_idx_reg;
        mem_re = 1'b0;
        am_we = 1'b0;
        am_waddr = rd_idx_reg;
        am_wdata = {1'b0, key_reg};
        hm_we = 1'b0;
        hm_waddr = rd_idx_reg;
        hm_wdata = hits_rd_reg + 32'd1;
        resp.valid = 1'b0;
        resp.kind = op_reg;
        resp.drop = 1'b0;
        resp.status = bslf_pkg::ST_OK;
        resp.hits = '0;

        case (state_reg)
            S_CLEAR:
            begin
                am_we = 1'b1;
                am_waddr = clr_idx_reg;
                am_wdata = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_SCAN;
                    key_next = req.key;
                    op_next = req.op;
                    issue_idx_next = '0;
                    rd_pend_next = 1'b0;
                    free_found_next = 1'b0;
                end
            end
            S_SCAN:
            begin
                // One entry is read per cycle; its data is checked in the next cycle.
                if (issue_idx_reg < ENTRY_COUNT)
                begin
                    mem_re = 1'b1;
                    issue_idx_next = issue_idx_reg + 1'b1;
                    rd_pend_next = 1'b1;
                    rd_idx_next = mem_raddr;
                end
                else
                begin
                    rd_pend_next = 1'b0;
                end
                if (free_now && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next = rd_idx_reg;
                end
                if (scan_end)
                begin
                    state_next = S_IDLE;
                    rd_pend_next = 1'b0;
                    resp.valid = 1'b1;
                    case (op_reg)
                        bslf_pkg::REQ_FRAME:
                        begin
                            resp.drop = hit;
                            hm_we = hit;
                        end
                        bslf_pkg::REQ_INSERT:
                        begin
                            if (hit)
                            begin
                                resp.status = bslf_pkg::ST_PRESENT;
                            end
                            else if (free_any)
                            begin
                                am_we = 1'b1;
                                am_waddr = free_sel;
                                am_wdata = {1'b1, key_reg};
                                hm_we = 1'b1;
                                hm_waddr = free_sel;
                                hm_wdata = '0;
                            end
                            else
                            begin
                                resp.status = bslf_pkg::ST_FULL;
                            end
                        end
                        bslf_pkg::REQ_REMOVE:
                        begin
                            if (hit)
                            begin
                                am_we = 1'b1;
                            end
                            else
                            begin
                                resp.status = bslf_pkg::ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            if (hit)
                            begin
                                resp.hits = hits_rd_reg;
                            end
                            else
                            begin
                                resp.status = bslf_pkg::ST_NOT_FOUND;
                            end
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_idx_reg <= '0;
            issue_idx_reg <= '0;
            rd_pend_reg <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_idx_reg <= clr_idx_next;
            issue_idx_reg <= issue_idx_next;
            rd_pend_reg <= rd_pend_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_idx_next;
        key_reg <= key_next;
        op_reg <= op_next;
        free_idx_reg <= free_idx_next;
    end

    always_ff @(posedge clk)
    begin
        if (am_we)
        begin
            addr_mem[am_waddr] <= am_wdata;
        end
        if (mem_re)
        begin
            addr_rd_reg <= addr_mem[mem_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (hm_we)
        begin
            hits_mem[hm_waddr] <= hm_wdata;
        end
        if (mem_re)
        begin
            hits_rd_reg <= hits_mem[mem_raddr];
        end
    end

endmodule

FILE: sv/ipv4_source_blocklist_filter_top.sv
// Channel   Handshake          Ports
// request   start / busy       req_type, data_byte, last_byte, table_address
// reply     done (one cycle)   reply_kind, drop_frame, status, hit_count
//
// A frame byte that is not the last is taken without a scan and gives no reply.
// A final byte of a short or non-IPv4 frame gives its verdict on the next cycle.
// Table requests and IPv4 verdicts scan the address memory one entry per cycle,
// stopping early when the address is found.
// After reset the valid flags of all entries are cleared while busy is high.
// Replies cannot be held off; done marks each reply beat for one cycle.
module ipv4_source_blocklist_filter_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  req_type,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic [31:0] table_address,
    output logic        done,
    output logic [1:0]  reply_kind,
    output logic        drop_frame,
    output logic [1:0]  status,
    output logic [31:0] hit_count
);

    logic                   accept;
    logic                   byte_beat;
    logic                   direct;
    bslf_pkg::frame_done_t  frame_done;
    bslf_pkg::table_req_t   treq;
    bslf_pkg::table_resp_t  tresp;

    logic        done_reg, done_next;
    logic [1:0]  kind_reg, kind_next;
    logic        drop_reg, drop_next;
    logic [1:0]  status_reg, status_next;
    logic [31:0] hits_reg, hits_next;

    assign accept = start && !busy;
    assign byte_beat = accept && (req_type == bslf_pkg::REQ_FRAME);

    bslf_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat       (byte_beat),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .frame_done (frame_done)
    );

    always_comb
    begin
        treq.valid = (accept && req_type != bslf_pkg::REQ_FRAME)
                     || (frame_done.valid && frame_done.eligible);
        treq.op = req_type;
        treq.key = (req_type == bslf_pkg::REQ_FRAME) ? frame_done.source : table_address;
    end

    bslf_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (treq),
        .resp  (tresp),
        .busy  (busy)
    );

    // A table reply only appears while busy, so it never meets a direct verdict.
    assign direct = frame_done.valid && !frame_done.eligible;

    always_comb
    begin
        done_next = tresp.valid || direct;
        if (tresp.valid)
        begin
            kind_next = tresp.kind;
            drop_next = tresp.drop;
            status_next = tresp.status;
            hits_next = tresp.hits;
        end
        else
        begin
            kind_next = bslf_pkg::REQ_FRAME;
            drop_next = 1'b0;
            status_next = bslf_pkg::ST_OK;
            hits_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        drop_reg <= drop_next;
        status_reg <= status_next;
        hits_reg <= hits_next;
    end

    assign done = done_reg;
    assign reply_kind = kind_reg;
    assign drop_frame = drop_reg;
    assign status = status_reg;
    assign hit_count = hits_reg;

endmodule

FILE: sv/bslf_checker.sv
module bslf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  req_type,
    input logic        last_byte,
    input logic        done,
    input logic [1:0]  reply_kind,
    input logic        drop_frame,
    input logic [1:0]  status,
    input logic [31:0] hit_count
);

    // Every table request is served by a scan, so the block goes busy once it is accepted.
    a_table_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type != bslf_pkg::REQ_FRAME |=> busy)
        else $error("table request did not start a scan");

    a_drop_only_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        done && drop_frame |-> reply_kind == bslf_pkg::REQ_FRAME && status == bslf_pkg::ST_OK)
        else $error("drop flag on a table reply");

    a_hits_only_read: assert property (@(posedge clk) disable iff (!rst_n)
        done && reply_kind != bslf_pkg::REQ_READ |-> hit_count == 32'd0)
        else $error("hit count outside a counter reply");

    a_mid_frame_silent: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && req_type == bslf_pkg::REQ_FRAME && !last_byte |=> !done)
        else $error("reply after a mid-frame byte");

endmodule

bind ipv4_source_blocklist_filter_top bslf_checker u_bslf_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .last_byte  (last_byte),
    .done       (done),
    .reply_kind (reply_kind),
    .drop_frame (drop_frame),
    .status     (status),
    .hit_count  (hit_count)
);
